/* rtl/core/cau_pkg.sv */
// Package: complex ALU opcodes, status codes and item types.
package cau_pkg;
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_CDIV = 4'd3;
    localparam logic [3:0] OP_RDIV = 4'd4;
    localparam logic [3:0] OP_CONJ = 4'd5;
    localparam logic [3:0] OP_NEG = 4'd6;
    localparam logic [3:0] OP_POW = 4'd7;
    localparam logic [3:0] OP_EQ = 4'd8;
    localparam logic [3:0] OP_ISREAL = 4'd9;
    localparam logic [3:0] OP_MAG = 4'd10;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic [30:0] EPS_RESET = 31'd66;

    typedef struct packed {
        logic [3:0] req_type;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        logic [5:0] exponent;
    } cau_req_t;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic test_flag;
        logic [1:0] status;
    } cau_res_t;
endpackage

/* rtl/core/cau_divider.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
module cau_divider import cau_pkg::*; #(
    parameter int NB = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NB-1:0] num,
    input  logic [NB-1:0] den,
    output logic          done,
    output logic [NB-1:0] quo
);
    localparam int CB = $clog2(NB + 1);
    logic [NB-1:0] rem_reg, q_reg, d_reg;
    logic [CB-1:0] cnt_reg;
    logic busy_reg;
    logic [NB:0] sh;
    logic [NB:0] df;

    assign sh = {rem_reg, q_reg[NB-1]};
    assign df = sh - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= CB'(NB);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CB'(1)) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg <= num;
            d_reg <= den;
        end else if (busy_reg) begin
            if (!df[NB]) begin
                rem_reg <= df[NB-1:0];
                q_reg <= {q_reg[NB-2:0], 1'b1};
            end else begin
                rem_reg <= sh[NB-1:0];
                q_reg <= {q_reg[NB-2:0], 1'b0};
            end
        end
    end

    assign quo = q_reg;
endmodule

/* rtl/core/complex_arith_unit.sv */
// Top level: sequenced complex-number ALU with shared multiplier, divider and root.
//
// complex_arith_unit takes one request (two complex Q-format operands, an opcode and
// an exponent) and returns one result with a value, a test flag and a status. One
// item at a time: s_ready is high only while the sequencer is idle. A finished result
// waits in the output register on m_valid/m_ready, so the next item may be accepted
// and worked on meanwhile; it stalls only when its own result is ready to be handed
// into that register. Add, sub, conj, neg, the tests, rdiv by zero and unknown opcodes
// go from acceptance through the finish state to the output state. Multiply uses the
// one shared multiplier four times, as does cdiv by zero. Pow runs four multiplies and
// a round per power step. Rdiv runs the shared restoring divider twice over
// 2*WORD_BITS+FRAC_BITS+4 bits. Cdiv first forms both numerators and |b|^2 on the
// multiplier, then divides twice. Magnitude runs a bit-by-bit root over WORD_BITS
// multiply-compare steps plus one rounding multiply. A new result waits in S_OUT while
// an earlier one is held with m_ready low. Epsilon is written by cfg_we with cfg_data
// at any edge and resets to about 0.001.
module complex_arith_unit import cau_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int MAX_POWER = 63
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cau_req_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cau_res_t  m_data,
    input  logic      cfg_we,
    input  logic [30:0] cfg_data
);
    localparam int W = WORD_BITS;
    localparam int OB = (W < 32) ? W : 32;
    localparam int PB = 2 * W + 2;             // product/sum width
    localparam int DB = PB + FRAC_BITS + 2;    // divider width
    localparam int RB = W;                     // root bits
    localparam int EB = 8;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0 = 4'd1;
    localparam logic [3:0] S_M1 = 4'd2;
    localparam logic [3:0] S_M2 = 4'd3;
    localparam logic [3:0] S_M3 = 4'd4;
    localparam logic [3:0] S_MFIN = 4'd5;
    localparam logic [3:0] S_DIV = 4'd6;
    localparam logic [3:0] S_DWAIT = 4'd7;
    localparam logic [3:0] S_SQ = 4'd8;
    localparam logic [3:0] S_SQFIN = 4'd9;
    localparam logic [3:0] S_FIN = 4'd10;
    localparam logic [3:0] S_OUT = 4'd11;
    localparam logic [3:0] S_D0 = 4'd12;
    localparam logic [3:0] S_D1 = 4'd13;

    logic [30:0] eps_reg;
    logic [3:0] state_reg, op_reg;
    logic signed [W-1:0] ar_reg, ai_reg, br_reg, bi_reg, zr_reg, zi_reg;
    logic signed [PB-1:0] acc_reg, den_reg, vr_reg, vi_reg;
    logic [EB-1:0] pw_reg;
    logic [1:0] st_reg;
    logic flag_reg, half_reg, neg_reg;
    logic [$clog2(RB)-1:0] rb_reg;
    logic [RB-1:0] root_reg;
    cau_res_t out_reg;
    logic valid_reg;

    // Shared multiplier: operands selected by state; the product is combinational and is registered by the state logic.
    logic signed [W:0] mx, my;
    logic signed [2*W+1:0] prod;

    function automatic logic signed [W-1:0] ld(input logic signed [31:0] v);
        return W'(v);
    endfunction

    function automatic logic signed [PB-1:0] sat_to(input logic signed [PB-1:0] v,
                                                   input int bits, output logic ovf);
        logic signed [PB-1:0] mxv, mnv;
        mxv = (PB'(1) <<< (bits - 1)) - PB'(1);
        mnv = -(PB'(1) <<< (bits - 1));
        ovf = 1'b0;
        if (v > mxv) begin ovf = 1'b1; return mxv; end
        if (v < mnv) begin ovf = 1'b1; return mnv; end
        return v;
    endfunction

    function automatic logic signed [PB-1:0] rnd(input logic signed [PB-1:0] v);
        return (v + (PB'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    logic [RB-1:0] trial;
    always_comb begin
        trial = root_reg | (RB'(1) << rb_reg);
        mx = '0;
        my = '0;
        case (state_reg)
            S_M0: begin
                mx = (op_reg == OP_POW) ? zr_reg : ar_reg;
                my = (op_reg == OP_MAG) ? ar_reg
                   : (op_reg == OP_CDIV) ? br_reg : (op_reg == OP_POW) ? ar_reg : br_reg;
            end
            S_M1: begin
                mx = (op_reg == OP_POW) ? zi_reg : ai_reg;
                my = (op_reg == OP_MAG) ? ai_reg : (op_reg == OP_CDIV) ? bi_reg
                   : (op_reg == OP_POW) ? ai_reg : bi_reg;
            end
            S_M2: begin
                mx = (op_reg == OP_POW) ? zr_reg : ((op_reg == OP_CDIV) ? ai_reg : ar_reg);
                my = (op_reg == OP_POW) ? ai_reg : ((op_reg == OP_CDIV) ? br_reg : bi_reg);
            end
            S_M3: begin
                mx = (op_reg == OP_POW) ? zi_reg : ((op_reg == OP_CDIV) ? ar_reg : ai_reg);
                my = (op_reg == OP_POW) ? ar_reg : ((op_reg == OP_CDIV) ? bi_reg : br_reg);
            end
            S_D0: begin
                mx = br_reg;
                my = br_reg;
            end
            S_D1: begin
                mx = bi_reg;
                my = bi_reg;
            end
            S_SQ: begin
                mx = $signed({1'b0, trial});
                my = $signed({1'b0, trial});
            end
            S_SQFIN: begin
                mx = $signed({1'b0, root_reg});
                my = $signed({1'b0, root_reg});
            end
            default: ;
        endcase
    end
    assign prod = mx * my;

    // Divider: |num| * 2 + |den| over 2*|den|, rounded half away from zero.
    logic dv_start, dv_done;
    logic [DB-1:0] dv_num, dv_den, dv_quo;
    logic signed [PB+FRAC_BITS-1:0] numr;
    logic [PB+FRAC_BITS-1:0] anum;
    logic [PB-1:0] aden;
    always_comb begin
        numr = (half_reg ? (PB+FRAC_BITS)'(vi_reg) : (PB+FRAC_BITS)'(vr_reg)) <<< FRAC_BITS;
        anum = numr[PB+FRAC_BITS-1] ? -numr : numr;
        aden = den_reg[PB-1] ? -den_reg : den_reg;
        dv_num = DB'({anum, 1'b0}) + DB'(aden);
        dv_den = DB'({aden, 1'b0});
    end

    cau_divider #(.NB(DB)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .num(dv_num), .den(dv_den), .done(dv_done), .quo(dv_quo)
    );
    assign dv_start = (state_reg == S_DIV);

    logic signed [PB-1:0] qs;
    assign qs = (numr[PB+FRAC_BITS-1] ^ den_reg[PB-1]) ? -PB'(dv_quo) : PB'(dv_quo);

    // Final saturation of both parts to port range, and rounded saturation to word range for pow steps.
    logic o1, o2, p1, p2;
    logic signed [PB-1:0] fr, fi, pr, pi;
    always_comb begin
        fr = sat_to(vr_reg, OB, o1);
        fi = sat_to(vi_reg, OB, o2);
        pr = sat_to(rnd(vr_reg), W, p1);
        pi = sat_to(rnd(vi_reg), W, p2);
    end

    logic signed [PB-1:0] ra, rb;
    logic signed [PB-1:0] d1, d2, d3;
    always_comb begin
        ra = PB'(ar_reg);
        rb = PB'(br_reg);
        d1 = PB'(ar_reg) - PB'(br_reg);
        d2 = PB'(ai_reg) - PB'(bi_reg);
        d3 = PB'(ai_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg <= s_data.req_type;
                        ar_reg <= ld(s_data.a_re);
                        ai_reg <= ld(s_data.a_im);
                        br_reg <= ld(s_data.b_re);
                        bi_reg <= ld(s_data.b_im);
                        pw_reg <= (EB'(s_data.exponent) > EB'(MAX_POWER)) ? EB'(MAX_POWER)
                                                                          : EB'(s_data.exponent);
                        zr_reg <= W'(PB'(1) <<< FRAC_BITS);
                        zi_reg <= '0;
                        st_reg <= ST_OK;
                        flag_reg <= 1'b0;
                        half_reg <= 1'b0;
                        vr_reg <= '0;
                        vi_reg <= '0;
                        root_reg <= '0;
                        rb_reg <= ($clog2(RB))'(RB - 1);
                        // ops without products go straight to the finish
                        case (s_data.req_type)
                            OP_ADD, OP_SUB, OP_CONJ, OP_NEG, OP_EQ, OP_ISREAL:
                                state_reg <= S_FIN;
                            OP_RDIV: state_reg <= S_FIN;
                            OP_MUL, OP_CDIV, OP_MAG: state_reg <= S_M0;
                            OP_POW: state_reg <= S_M0;
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                S_M0: begin
                    if (op_reg == OP_POW && pw_reg == '0) begin
                        vr_reg <= PB'(zr_reg);
                        vi_reg <= PB'(zi_reg);
                        state_reg <= S_OUT;
                    end else begin
                        acc_reg <= PB'(prod);
                        if (op_reg == OP_MAG) begin
                            state_reg <= S_M1;
                        end else begin
                            state_reg <= S_M1;
                        end
                    end
                end
                S_M1: begin
                    // real part: ac -/+ bd
                    vr_reg <= (op_reg == OP_MUL || op_reg == OP_POW) ? acc_reg - PB'(prod)
                                                                     : acc_reg + PB'(prod);
                    state_reg <= (op_reg == OP_MAG) ? S_SQ : S_M2;
                end
                S_M2: begin
                    acc_reg <= PB'(prod);
                    state_reg <= S_M3;
                end
                S_M3: begin
                    vi_reg <= (op_reg == OP_CDIV) ? acc_reg - PB'(prod) : acc_reg + PB'(prod);
                    state_reg <= S_MFIN;
                end
                S_MFIN: begin
                    if (op_reg == OP_CDIV) begin
                        // zero divisor: drop the numerators and flag it
                        if (br_reg == '0 && bi_reg == '0) begin
                            st_reg <= ST_DIVZ;
                            vr_reg <= '0;
                            vi_reg <= '0;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_D0;
                        end
                    end else if (op_reg == OP_POW) begin
                        zr_reg <= W'(pr);
                        zi_reg <= W'(pi);
                        if (p1 || p2) st_reg <= ST_OVF;
                        pw_reg <= pw_reg - 1'b1;
                        state_reg <= S_M0;
                    end else begin
                        vr_reg <= rnd(vr_reg);
                        vi_reg <= rnd(vi_reg);
                        state_reg <= S_OUT;
                    end
                end
                S_D0: begin
                    acc_reg <= PB'(prod);
                    state_reg <= S_D1;
                end
                S_D1: begin
                    // cdiv divisor c^2 + d^2
                    den_reg <= acc_reg + PB'(prod);
                    state_reg <= S_DIV;
                end
                S_DIV: state_reg <= S_DWAIT;
                S_DWAIT: begin
                    if (dv_done) begin
                        if (!half_reg) begin
                            vr_reg <= qs;
                            half_reg <= 1'b1;
                            state_reg <= S_DIV;
                        end else begin
                            vi_reg <= qs;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SQ: begin
                    if (PB'(prod) <= vr_reg) root_reg <= trial;
                    if (rb_reg == '0) state_reg <= S_SQFIN;
                    else rb_reg <= rb_reg - 1'b1;
                end
                S_SQFIN: begin
                    // round: bump when n - r^2 > r
                    acc_reg <= vr_reg - PB'(prod);
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    state_reg <= (op_reg == OP_RDIV && br_reg != '0) ? S_DIV : S_OUT;
                    case (op_reg)
                        OP_ADD: begin vr_reg <= ra + rb; vi_reg <= d3 + PB'(bi_reg); end
                        OP_SUB: begin vr_reg <= d1; vi_reg <= d2; end
                        OP_CONJ: begin vr_reg <= ra; vi_reg <= -d3; end
                        OP_NEG: begin vr_reg <= -ra; vi_reg <= -d3; end
                        OP_EQ: flag_reg <= ((d1[PB-1] ? -d1 : d1) < PB'(eps_reg))
                                         && ((d2[PB-1] ? -d2 : d2) < PB'(eps_reg));
                        OP_ISREAL: flag_reg <= ((d3[PB-1] ? -d3 : d3) < PB'(eps_reg));
                        OP_RDIV: begin
                            if (br_reg == '0) begin
                                st_reg <= ST_DIVZ;
                            end else begin
                                vr_reg <= PB'(ar_reg);
                                vi_reg <= PB'(ai_reg);
                                den_reg <= PB'(br_reg);
                            end
                        end
                        OP_MAG: begin
                            vr_reg <= (acc_reg > PB'(root_reg)) ? PB'(root_reg) + PB'(1)
                                                                : PB'(root_reg);
                            vi_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    if (!valid_reg || m_ready) begin
                        out_reg.res_re <= 32'(fr);
                        out_reg.res_im <= 32'(fi);
                        out_reg.test_flag <= flag_reg;
                        out_reg.status <= (o1 || o2) ? ST_OVF : st_reg;
                        valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (valid_reg && m_ready && state_reg != S_OUT) valid_reg <= 1'b0;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = valid_reg;
    assign m_data = out_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_flag_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.test_flag |-> m_data.status == ST_OK) else $error("flag status");
`endif
endmodule
